// ----- hw/rtl/rtu_frame_crc_checker_core_assert.svh -----
// Assertion macros used by the frame CRC checker top module.
// Each macro checks on the rising edge of clk and is disabled during reset.
`ifndef RTU_FRAME_CRC_CHECKER_CORE_ASSERT_SVH
`define RTU_FRAME_CRC_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RFCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rfcc_pkg.sv -----
package rfcc_pkg;

  // CRC-16 as used on Modbus serial lines: reflected polynomial, all-ones start.
  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Frame length limits; the byte count saturates at the minimum frame length.
  localparam logic [2:0] MIN_FRAME = 3'd4;
  localparam logic [2:0] CRC_BYTES = 3'd2;
  localparam logic [2:0] CNT_ADDR  = 3'd2;
  localparam logic [2:0] CNT_FUNC  = 3'd3;

  // Role codes of a result transaction.
  localparam logic [1:0] ROLE_ADDR   = 2'd0;
  localparam logic [1:0] ROLE_FUNC   = 2'd1;
  localparam logic [1:0] ROLE_DATA   = 2'd2;
  localparam logic [1:0] ROLE_STATUS = 2'd3;

  // Status codes carried on the status transaction.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_CRC   = 2'd2;

  // Job queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] role;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Work for the back part that one accepted byte produces.
  typedef struct packed {
    logic       fwd_valid;
    logic [7:0] fwd_byte;
    logic [1:0] fwd_role;
    logic       end_valid;
    logic [1:0] end_status;
  } job_t;

  // Queue status seen by the back part and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Byte-wide CRC update, unrolled over the eight bits.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/rfcc_front.sv -----
module rfcc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  rfcc_pkg::in_item_t item,
  output logic              push,
  output rfcc_pkg::job_t    job
);

  logic [15:0] crc;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [2:0]  count;

  logic        fwd;
  logic [15:0] crc_upd;
  logic [2:0]  count_inc;
  logic [15:0] rx_crc;

  // Classify the byte leaving the hold-back window, fold it into the CRC and judge a frame end.
  always_comb begin
    fwd       = (count >= rfcc_pkg::CRC_BYTES);
    crc_upd   = fwd ? rfcc_pkg::crc_feed(crc, held0) : crc;
    count_inc = (count < rfcc_pkg::MIN_FRAME) ? count + 3'd1 : count;
    rx_crc    = {item.rx_byte, held1};

    job.fwd_valid = fwd;
    job.fwd_byte  = held0;
    if (count == rfcc_pkg::CNT_ADDR) begin
      job.fwd_role = rfcc_pkg::ROLE_ADDR;
    end else if (count == rfcc_pkg::CNT_FUNC) begin
      job.fwd_role = rfcc_pkg::ROLE_FUNC;
    end else begin
      job.fwd_role = rfcc_pkg::ROLE_DATA;
    end

    job.end_valid = item.frame_end;
    if (count_inc < rfcc_pkg::MIN_FRAME) begin
      job.end_status = rfcc_pkg::ST_SHORT;
    end else if (rx_crc == crc_upd) begin
      job.end_status = rfcc_pkg::ST_OK;
    end else begin
      job.end_status = rfcc_pkg::ST_CRC;
    end

    push = take && (fwd || item.frame_end);
  end

  // Frame state: running CRC and saturating byte count restart at frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= rfcc_pkg::CRC_START;
      count <= 3'd0;
    end else if (take) begin
      if (item.frame_end) begin
        crc   <= rfcc_pkg::CRC_START;
        count <= 3'd0;
      end else begin
        crc   <= crc_upd;
        count <= count_inc;
      end
    end
  end

  // The two newest bytes are held back as possible CRC bytes.
  always_ff @(posedge clk) begin
    if (take) begin
      held0 <= held1;
      held1 <= item.rx_byte;
    end
  end

endmodule

// ----- hw/rtl/rfcc_queue.sv -----
module rfcc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rfcc_pkg::job_t     wr_job,
  input  logic               pop,
  output rfcc_pkg::job_t     rd_job,
  output rfcc_pkg::q_stat_t  stat
);

  rfcc_pkg::job_t mem [rfcc_pkg::QDEPTH];

  logic [rfcc_pkg::QPTR_W-1:0] wr_ptr;
  logic [rfcc_pkg::QPTR_W-1:0] rd_ptr;
  logic [rfcc_pkg::QCNT_W-1:0] count;

  // Status flags and head entry.
  always_comb begin
    stat.full  = (count == rfcc_pkg::QCNT_W'(rfcc_pkg::QDEPTH));
    stat.empty = (count == '0);
    rd_job     = mem[rd_ptr];
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rfcc_back.sv -----
module rfcc_back (
  input  logic               clk,
  input  logic               rst,
  input  rfcc_pkg::job_t     job,
  input  rfcc_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output rfcc_pkg::out_item_t result_item
);

  logic                pend;
  logic                pend_next;
  logic [1:0]          pend_status;
  logic [1:0]          pend_status_next;
  logic                out_valid;
  logic                out_valid_next;
  rfcc_pkg::out_item_t out_item;
  rfcc_pkg::out_item_t out_item_next;
  logic                load;

  // Expand each job into one or two result transactions, one per cycle unless the output is stalled.
  always_comb begin
    load             = !out_valid || !result_stall;
    pop              = 1'b0;
    pend_next        = pend;
    pend_status_next = pend_status;
    out_valid_next   = out_valid;
    out_item_next    = out_item;
    if (load) begin
      if (pend) begin
        out_valid_next       = 1'b1;
        out_item_next        = '0;
        out_item_next.role   = rfcc_pkg::ROLE_STATUS;
        out_item_next.status = pend_status;
        out_item_next.last   = 1'b1;
        pend_next            = 1'b0;
      end else if (!q_stat.empty) begin
        pop            = 1'b1;
        out_valid_next = 1'b1;
        out_item_next  = '0;
        if (job.fwd_valid) begin
          out_item_next.out_byte = job.fwd_byte;
          out_item_next.role     = job.fwd_role;
          pend_next              = job.end_valid;
          pend_status_next       = job.end_status;
        end else begin
          out_item_next.role   = rfcc_pkg::ROLE_STATUS;
          out_item_next.status = job.end_status;
          out_item_next.last   = 1'b1;
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  // Output register and pending status.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    out_item    <= out_item_next;
    pend_status <= pend_status_next;
  end

  assign result_valid = out_valid;
  assign result_item  = out_item;

endmodule

// ----- hw/rtl/rtu_frame_crc_checker_core.sv -----
// Modbus RTU frame CRC checker. Frame bytes enter one per transaction with
// frame_end marking the last byte. The two newest bytes are held back; each
// older byte leaves as an address, function or data transaction and feeds a
// running CRC-16 (reflected 0xA001, start 0xFFFF). The final byte produces a
// status transaction (ok, too short, CRC mismatch) with last set, comparing
// the CRC against the last two bytes, low byte first; the frame state then
// restarts. Input bytes are accepted one per clock cycle while the queue has
// room; the CRC update for a byte is one unrolled stage in the front part.
// Results leave one per cycle, unless stalled, from the back part's output
// register, so a final byte that also forwards a byte needs two result
// transactions; a four-entry job queue between the parts absorbs this and
// stalls input only when it is full.
`include "rtu_frame_crc_checker_core_assert.svh"

module rtu_frame_crc_checker_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  rfcc_pkg::in_item_t  byte_item,
  output logic                result_valid,
  input  logic                result_stall,
  output rfcc_pkg::out_item_t result_item
);

  logic              take;
  logic              push;
  logic              pop;
  rfcc_pkg::job_t    wr_job;
  rfcc_pkg::job_t    rd_job;
  rfcc_pkg::q_stat_t q_stat;

  // Input transaction is taken whenever the queue has room.
  assign byte_stall = q_stat.full;
  assign take       = byte_valid && !byte_stall;

  rfcc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (byte_item),
    .push (push),
    .job  (wr_job)
  );

  rfcc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  rfcc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (rd_job),
    .q_stat       (q_stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  `RFCC_ASSERT_NOW(a_status_last, result_valid && result_item.role == rfcc_pkg::ROLE_STATUS, result_item.last, "status transaction without last")
  `RFCC_ASSERT_NOW(a_fwd_clean, result_valid && result_item.role != rfcc_pkg::ROLE_STATUS, result_item.status == rfcc_pkg::ST_OK && !result_item.last, "forwarded byte with status or last")
  `RFCC_ASSERT_NOW(a_q_flags, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty at once")
  `RFCC_ASSERT_NEXT(a_end_queued, take && byte_item.frame_end, !q_stat.empty, "frame end produced no queued job")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int ITEM_TARGET  = 450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLDOFF_AT   = 150;
  localparam int HOLDOFF_LEN  = 64;

  // One byte waiting to be offered, with its lead-in gap and pause request.
  typedef struct {
    rfcc_pkg::in_item_t item;
    int                 gap;
    bit                 drain;
  } rx_slot_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  rfcc_pkg::in_item_t  byte_item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  rfcc_pkg::out_item_t result_item;

  rx_slot_t            rx_pending[$];
  rfcc_pkg::out_item_t frame_expect[$];

  // Shadow copy of the checker's frame state.
  logic [15:0] crc_acc   = rfcc_pkg::CRC_START;
  logic [7:0]  hold_old  = 8'h00;
  logic [7:0]  hold_new  = 8'h00;
  logic [2:0]  frame_cnt = 3'd0;

  bit in_accepted = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;
  int free_left   = 0;
  int errors      = 0;
  int idle_cycles = 0;
  int n_items     = 0;
  int n_checked   = 0;
  int n_fwd       = 0;
  int n_ok        = 0;
  int n_short     = 0;
  int n_crc       = 0;
  int n_backpressure = 0;

  rtu_frame_crc_checker_core dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Modbus CRC-16, one data bit folded in per shift.
  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c = c >> 1;
      if (fb) begin
        c = c ^ rfcc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  // Back-to-back in a burst; otherwise mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  // Work out the results that one accepted byte causes.
  task automatic predict_byte(input rfcc_pkg::in_item_t it);
    rfcc_pkg::out_item_t r;
    logic [15:0]         rx_crc;
    if (frame_cnt >= rfcc_pkg::CRC_BYTES) begin
      r = '0;
      r.out_byte = hold_old;
      r.role = (frame_cnt == rfcc_pkg::CNT_ADDR) ? rfcc_pkg::ROLE_ADDR :
               (frame_cnt == rfcc_pkg::CNT_FUNC) ? rfcc_pkg::ROLE_FUNC :
               rfcc_pkg::ROLE_DATA;
      crc_acc = crc16_next(crc_acc, hold_old);
      frame_expect = {frame_expect, r};
    end
    hold_old = hold_new;
    hold_new = it.rx_byte;
    if (frame_cnt < rfcc_pkg::MIN_FRAME) begin
      frame_cnt = frame_cnt + 3'd1;
    end
    if (it.frame_end) begin
      r = '0;
      r.role = rfcc_pkg::ROLE_STATUS;
      r.last = 1'b1;
      rx_crc = {hold_new, hold_old};
      if (frame_cnt < rfcc_pkg::MIN_FRAME) begin
        r.status = rfcc_pkg::ST_SHORT;
      end else if (rx_crc == crc_acc) begin
        r.status = rfcc_pkg::ST_OK;
      end else begin
        r.status = rfcc_pkg::ST_CRC;
      end
      frame_expect = {frame_expect, r};
      crc_acc = rfcc_pkg::CRC_START;
      frame_cnt = 3'd0;
    end
  endtask

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Compare one result transaction against the oldest expectation.
  task automatic check_result(input rfcc_pkg::out_item_t got);
    rfcc_pkg::out_item_t want;
    if (frame_expect.size() == 0) begin
      report_error($sformatf("unexpected result: byte=%02h role=%0d status=%0d last=%b",
                             got.out_byte, got.role, got.status, got.last));
      return;
    end
    want = frame_expect.pop_front();
    n_checked++;
    if (got.out_byte !== want.out_byte || got.role !== want.role ||
        got.status !== want.status || got.last !== want.last) begin
      report_error($sformatf({"mismatch: expected byte=%02h role=%0d status=%0d last=%b,",
                              " got byte=%02h role=%0d status=%0d last=%b"},
                             want.out_byte, want.role, want.status, want.last,
                             got.out_byte, got.role, got.status, got.last));
    end else if (want.role != rfcc_pkg::ROLE_STATUS) begin
      n_fwd++;
    end else if (want.status == rfcc_pkg::ST_OK) begin
      n_ok++;
    end else if (want.status == rfcc_pkg::ST_SHORT) begin
      n_short++;
    end else begin
      n_crc++;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit fin, input int gap, input bit drain);
    rx_slot_t s;
    s.item.rx_byte = b;
    s.item.frame_end = fin;
    s.gap = gap;
    s.drain = drain;
    rx_pending = {rx_pending, s};
    n_items++;
  endtask

  // Queue the given bytes as one frame, frame_end on the last byte.
  task automatic queue_raw(input logic [7:0] bytes_q[$], input bit burst, input bit drain);
    foreach (bytes_q[i]) begin
      queue_byte(bytes_q[i], i == bytes_q.size() - 1, pick_gap(burst), drain && i == 0);
    end
  endtask

  // Append the CRC, low byte first, optionally corrupted by one bit.
  task automatic queue_frame(input logic [7:0] bytes_q[$], input bit crc_good, input bit burst,
                             input bit drain);
    logic [15:0] c;
    c = rfcc_pkg::CRC_START;
    foreach (bytes_q[i]) begin
      c = crc16_next(c, bytes_q[i]);
    end
    if (!crc_good) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    bytes_q = {bytes_q, c[7:0], c[15:8]};
    queue_raw(bytes_q, burst, drain);
  endtask

  // Sender: offers the next pending byte once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || in_accepted) begin
      if (rx_pending.size() == 0) begin
        byte_valid <= 1'b0;
      end else if (rx_pending[0].gap != 0) begin
        rx_pending[0].gap = rx_pending[0].gap - 1;
        byte_valid <= 1'b0;
      end else if (rx_pending[0].drain && frame_expect.size() != 0) begin
        byte_valid <= 1'b0;
      end else begin
        byte_item <= rx_pending[0].item;
        byte_valid <= 1'b1;
        void'(rx_pending.pop_front());
      end
    end
  end

  // Receiver: random stall runs, plus one long hold-off to fill the checker.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (!hold_done && n_checked >= HOLDOFF_AT) begin
      hold_done = 1'b1;
      hold_left = HOLDOFF_LEN - 1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      result_stall <= 1'b0;
    end else begin
      free_left = ($urandom_range(0, 99) < 20) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
      hold_left = pick_gap(1'b0);
      result_stall <= 1'b0;
    end
  end

  // Sample both handshakes; predict first so a same-edge result finds its entry.
  always @(posedge clk) begin
    in_accepted = 1'b0;
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        in_accepted = 1'b1;
        predict_byte(byte_item);
      end
      if (byte_valid && byte_stall) begin
        n_backpressure++;
      end
      if (result_valid && !result_stall) begin
        check_result(result_item);
      end
      if (in_accepted || (result_valid && !result_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
                 IDLE_LIMIT, frame_expect.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] body[$];
    int         kind;
    int         len;
    int         next_drain;
    bit         burst;

    // Directed frames: every short length, both CRC outcomes, byte extremes.
    body = {8'h00};
    queue_raw(body, 1'b1, 1'b0);
    body = {8'hFF, 8'h00};
    queue_raw(body, 1'b1, 1'b0);
    body = {8'h80, 8'h01, 8'hFE};
    queue_raw(body, 1'b1, 1'b0);
    body = {8'hFF, 8'h00};
    queue_frame(body, 1'b1, 1'b1, 1'b0);
    body = {8'h00, 8'hFF};
    queue_frame(body, 1'b0, 1'b1, 1'b0);
    body = {8'h01, 8'h03, 8'h00, 8'hFF};
    queue_frame(body, 1'b1, 1'b0, 1'b0);

    // Random traffic: mostly well-formed frames, some corrupt, short or noisy.
    next_drain = n_items;
    while (n_items < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      burst = ($urandom_range(0, 3) == 0);
      body.delete();
      if (kind < 72) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 8);
      end else if (kind < 84) begin
        len = $urandom_range(2, 10);
      end else if (kind < 92) begin
        len = $urandom_range(1, 3);
      end else begin
        len = $urandom_range(1, 16);
      end
      for (int i = 0; i < len; i++) begin
        body = {body, 8'($urandom_range(0, 255))};
      end
      if (kind < 92) begin
        if (kind < 84) begin
          queue_frame(body, kind < 72, burst, n_items >= next_drain);
        end else begin
          queue_raw(body, burst, n_items >= next_drain);
        end
        if (n_items >= next_drain) begin
          next_drain = n_items + $urandom_range(60, 100);
        end
      end else begin
        // Noise: random bytes with frame ends at random places.
        foreach (body[i]) begin
          queue_byte(body[i], i == body.size() - 1 || $urandom_range(0, 5) == 0,
                     pick_gap(burst), 1'b0);
        end
      end
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Wait for the last byte to be taken, then for every result to arrive.
    while (rx_pending.size() != 0 || byte_valid) @(negedge clk);
    while (frame_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d bytes; checked %0d forwarded bytes and %0d/%0d/%0d ok/short/CRC frames.",
             n_items, n_fwd, n_ok, n_short, n_crc);
    $display("Input was stalled by the checker on %0d cycles; %0d errors.",
             n_backpressure, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/rfcc_pkg.sv
hw/rtl/rfcc_front.sv
hw/rtl/rfcc_queue.sv
hw/rtl/rfcc_back.sv
hw/rtl/rtu_frame_crc_checker_core.sv
tb/tb.sv
